FILE: rtl/core/md5_message_digest_macros.svh
// Assertion macros shared by the MD5 digest modules.
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MD5_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 check failed: next-cycle implication");

`endif

FILE: rtl/core/md5_pkg.sv
// Types, constants and round tables shared by the MD5 digest modules.
package md5_pkg;

   localparam int LEN_W = 61;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Pointer values that steer the padding sequence.
   localparam logic [5:0] PTR_LAST = 6'd63;
   localparam logic [5:0] PTR_LEN  = 6'd56;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef enum logic [1:0] {
      SEL_MSG  = 2'd0,
      SEL_PAD  = 2'd1,
      SEL_ZERO = 2'd2,
      SEL_LEN  = 2'd3
   } byte_sel_type;

   typedef struct packed {
      logic         write_en;
      byte_sel_type byte_sel;
      logic         count_len;
      logic         start;
      logic         restart;
      logic [1:0]   word_sel;
   } md5_cmd_type;

   typedef struct packed {
      logic ptr_last;
      logic ptr_high;
      logic ptr_len_start;
      logic round_done;
   } md5_status_type;

   function automatic logic [4:0] md5_rot_amount(input logic [5:0] round);
      return ROT_AMOUNT[{round[5:4], round[1:0]}];
   endfunction

endpackage

FILE: rtl/core/md5_ctrl.sv
// Controller for the MD5 digest: input acceptance, padding sequence and digest output.
`include "md5_message_digest_macros.svh"

module md5_ctrl
   import md5_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_tuser,
   input  logic           req_tlast,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [1:0]     rsp_tuser,
   output logic           rsp_tlast,
   output md5_cmd_type    cmd,
   input  md5_status_type status
);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_PAD_MARK   = 7'b0000010,
      ST_PAD_ZERO   = 7'b0000100,
      ST_PAD_LEN    = 7'b0001000,
      ST_COMP_START = 7'b0010000,
      ST_COMP_WAIT  = 7'b0100000,
      ST_EMIT       = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic       overflow_ff, overflow_in;
   logic [1:0] idx_ff, idx_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 2'd3);

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      overflow_in = overflow_ff;
      idx_in      = idx_ff;
      cmd         = '0;
      cmd.word_sel = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  cmd.write_en  = 1'b1;
                  cmd.byte_sel  = SEL_MSG;
                  cmd.count_len = 1'b1;
               end
               // A byte that fills the block is compressed before any finish.
               if (req_tuser && status.ptr_last) begin
                  ret_in   = req_tlast ? ST_PAD_MARK : ST_IDLE;
                  state_in = ST_COMP_START;
               end else if (req_tlast) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_PAD_MARK: begin
            cmd.write_en = 1'b1;
            cmd.byte_sel = SEL_PAD;
            overflow_in  = 1'b0;
            state_in     = ST_PAD_ZERO;
            if (status.ptr_last) begin
               ret_in   = ST_PAD_ZERO;
               state_in = ST_COMP_START;
            end else if (status.ptr_high) begin
               // No room left for the length: zero out this block, then another.
               overflow_in = 1'b1;
            end
         end
         ST_PAD_ZERO: begin
            if (overflow_ff) begin
               cmd.write_en = 1'b1;
               cmd.byte_sel = SEL_ZERO;
               if (status.ptr_last) begin
                  overflow_in = 1'b0;
                  ret_in      = ST_PAD_ZERO;
                  state_in    = ST_COMP_START;
               end
            end else if (status.ptr_len_start) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.write_en = 1'b1;
               cmd.byte_sel = SEL_ZERO;
            end
         end
         ST_PAD_LEN: begin
            cmd.write_en = 1'b1;
            cmd.byte_sel = SEL_LEN;
            if (status.ptr_last) begin
               ret_in   = ST_EMIT;
               state_in = ST_COMP_START;
            end
         end
         ST_COMP_START: begin
            cmd.start = 1'b1;
            state_in  = ST_COMP_WAIT;
         end
         ST_COMP_WAIT: begin
            if (status.round_done) begin
               state_in = ret_ff;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (idx_ff == 2'd3) begin
                  cmd.restart = 1'b1;
                  idx_in      = 2'd0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ret_ff      <= ST_IDLE;
         overflow_ff <= 1'b0;
         idx_ff      <= 2'd0;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         overflow_ff <= overflow_in;
         idx_ff      <= idx_in;
      end
   end

   `MD5_ASSERT_SAME(a_ready_excl_valid, clock, reset, req_tready, !rsp_tvalid)
   `MD5_ASSERT_SAME(a_done_while_wait, clock, reset, status.round_done,
                    state_ff == ST_COMP_WAIT)
   `MD5_ASSERT_NEXT(a_last_word_to_idle, clock, reset,
                    rsp_tvalid && rsp_tready && rsp_tlast, req_tready)
   `MD5_ASSERT_NEXT(a_start_then_wait, clock, reset, cmd.start,
                    state_ff == ST_COMP_WAIT)

endmodule

FILE: rtl/core/md5_datapath.sv
// Datapath for the MD5 digest: block store, length counter, round engine, chaining words.
`include "md5_message_digest_macros.svh"

module md5_datapath
   import md5_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  md5_cmd_type    cmd,
   input  logic [7:0]     message_byte,
   output md5_status_type status,
   output logic [31:0]    digest_word
);

   typedef enum logic [4:0] {
      STEP_READ = 5'b00001,
      STEP_KADD = 5'b00010,
      STEP_AADD = 5'b00100,
      STEP_FADD = 5'b01000,
      STEP_ROT  = 5'b10000
   } step_type;

   // Block store: sixteen little-endian words, written one byte at a time.
   logic [31:0] block_mem [16];
   logic [31:0] rd_ff;

   logic [5:0]       ptr_ff, ptr_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [31:0]      chain_ff [4];
   logic [31:0]      chain_in [4];
   logic [31:0]      a_ff, b_ff, c_ff, d_ff;
   logic [31:0]      a_in, b_in, c_in, d_in;
   logic [31:0]      sum_ff, sum_in;
   logic [5:0]       round_ff, round_in;
   step_type         step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             fin_ff, fin_in;

   logic [7:0]  wr_byte;
   logic [63:0] bit_len;
   logic [31:0] f_val;
   logic [3:0]  g_idx;
   logic [3:0]  r_low;
   logic [63:0] rot_wide;
   logic [31:0] rotated;

   assign bit_len = {len_ff, 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         SEL_MSG:  wr_byte = message_byte;
         SEL_PAD:  wr_byte = PAD_BYTE;
         SEL_ZERO: wr_byte = 8'h00;
         SEL_LEN:  wr_byte = bit_len[{ptr_ff[2:0], 3'b000} +: 8];
         default:  wr_byte = 8'h00;
      endcase
   end

   // Round function and message word index for the current round.
   assign r_low = round_ff[3:0];
   always_comb begin
      case (round_ff[5:4])
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            g_idx = r_low;
         end
         2'd1: begin
            f_val = (d_ff & b_ff) | (~d_ff & c_ff);
            g_idx = 4'(r_low * 4'd5 + 4'd1);
         end
         2'd2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            g_idx = 4'(r_low * 4'd3 + 4'd5);
         end
         default: begin
            f_val = c_ff ^ (b_ff | ~d_ff);
            g_idx = 4'(r_low * 4'd7);
         end
      endcase
   end

   assign rot_wide = {sum_ff, sum_ff} << md5_rot_amount(round_ff);
   assign rotated  = rot_wide[63:32];

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         block_mem[ptr_ff[5:2]][{ptr_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end
      rd_ff <= block_mem[g_idx];
   end

   always_comb begin
      ptr_in   = ptr_ff;
      len_in   = len_ff;
      chain_in = chain_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      sum_in   = sum_ff;
      round_in = round_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      fin_in   = 1'b0;

      if (cmd.write_en) begin
         ptr_in = ptr_ff + 6'd1;
      end
      if (cmd.count_len) begin
         len_in = len_ff + {{(LEN_W-1){1'b0}}, 1'b1};
      end
      if (cmd.start) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         round_in = 6'd0;
         step_in  = STEP_READ;
         busy_in  = 1'b1;
      end
      if (busy_ff) begin
         case (step_ff)
            STEP_READ: begin
               step_in = STEP_KADD;
            end
            STEP_KADD: begin
               sum_in  = rd_ff + ROUND_CONST[round_ff];
               step_in = STEP_AADD;
            end
            STEP_AADD: begin
               sum_in  = sum_ff + a_ff;
               step_in = STEP_FADD;
            end
            STEP_FADD: begin
               sum_in  = sum_ff + f_val;
               step_in = STEP_ROT;
            end
            STEP_ROT: begin
               a_in     = d_ff;
               d_in     = c_ff;
               c_in     = b_ff;
               b_in     = b_ff + rotated;
               round_in = round_ff + 6'd1;
               step_in  = STEP_READ;
               if (round_ff == 6'd63) begin
                  busy_in = 1'b0;
                  fin_in  = 1'b1;
               end
            end
            default: begin
               step_in = STEP_READ;
            end
         endcase
      end
      if (fin_ff) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end
      if (cmd.restart) begin
         ptr_in   = 6'd0;
         len_in   = '0;
         chain_in = '{IV_A, IV_B, IV_C, IV_D};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= 6'd0;
         len_ff   <= '0;
         chain_ff <= '{IV_A, IV_B, IV_C, IV_D};
         round_ff <= 6'd0;
         step_ff  <= STEP_READ;
         busy_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         ptr_ff   <= ptr_in;
         len_ff   <= len_in;
         chain_ff <= chain_in;
         round_ff <= round_in;
         step_ff  <= step_in;
         busy_ff  <= busy_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      sum_ff <= sum_in;
   end

   assign status.ptr_last      = (ptr_ff == PTR_LAST);
   assign status.ptr_high      = (ptr_ff >= PTR_LEN);
   assign status.ptr_len_start = (ptr_ff == PTR_LEN);
   assign status.round_done    = fin_ff;

   assign digest_word = chain_ff[cmd.word_sel];

   `MD5_ASSERT_SAME(a_no_write_in_rounds, clock, reset, busy_ff || fin_ff, !cmd.write_en)
   `MD5_ASSERT_NEXT(a_rounds_end_in_fin, clock, reset,
                    busy_ff && (step_ff == STEP_ROT) && (round_ff == 6'd63), fin_ff)
   `MD5_ASSERT_NEXT(a_start_then_busy, clock, reset, cmd.start, busy_ff)

endmodule

FILE: rtl/core/md5_message_digest.sv
// Throughput: one byte per cycle while a block fills; the 64th byte of a block stalls
// input for a compression: start, 64 rounds of read, K add, A add, F add and rotate steps,
// then the final add. End of message: padding plus one or two compressions, then
// four digest words, one per cycle while rsp_tready is high.
// Reset is synchronous: control clears, chaining words load the initial values and the
// length counter clears; the block store is not cleared and needs no clearing pass.
module md5_message_digest
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] message_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);

   md5_cmd_type    cmd;
   md5_status_type status;

   md5_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   md5_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_byte (req_tdata),
      .status       (status),
      .digest_word  (rsp_tdata)
   );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the MD5 digest block: streams directed and random messages and checks digests.
`timescale 1ns / 100ps

module tb_top;
   import md5_pkg::LEN_W;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 1000;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 2000;

   // Per-round rotate amounts, round group major, five bits each, entry 0 in the low bits.
   localparam logic [79:0] ROT_PACKED = {
      5'd21, 5'd15, 5'd10, 5'd6, 5'd23, 5'd16, 5'd11, 5'd4,
      5'd20, 5'd14, 5'd9, 5'd5, 5'd22, 5'd17, 5'd12, 5'd7
   };

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] message_byte
   logic        req_tuser;   // [0] byte_present
   logic        req_tlast;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] digest_word
   logic [1:0]  rsp_tuser;   // [1:0] word_index
   logic        rsp_tlast;   // last_word

   // Digest predictor state.
   logic [31:0]      chain_words [4];
   logic [7:0]       block_bytes [64];
   logic [LEN_W-1:0] byte_count;
   logic [31:0]      sine_table [64];
   digest_word_type  expected_words [$];

   int mismatch_count = 0;
   int accepted_items = 0;
   int messages_done  = 0;
   int hold_request   = 0;
   int cycle_count    = 0;
   bit idle_on        = 1'b1;
   bit stall_on       = 1'b1;

   md5_message_digest dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   task automatic restart_message();
      chain_words[0] = 32'h67452301;
      chain_words[1] = 32'hefcdab89;
      chain_words[2] = 32'h98badcfe;
      chain_words[3] = 32'h10325476;
      byte_count     = '0;
   endtask

   task automatic compress_block();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      int i, g;
      for (i = 0; i < 16; i++)
         m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = a + f + sine_table[i] + m[g];
         a = d;
         d = c;
         c = b;
         b = b + rotate_left(t, ROT_PACKED[5 * ((i / 16) * 4 + i % 4) +: 5]);
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endtask

   // Applies one accepted transaction to the predictor and queues the digest on a finish.
   task automatic absorb_item(input logic [7:0] data, input logic present, input logic fin);
      logic [63:0]     bit_len;
      digest_word_type w;
      int pos, k;
      if (present) begin
         pos = byte_count[5:0];
         block_bytes[pos] = data;
         byte_count = byte_count + 1'b1;
         if (pos == 63) compress_block();
      end
      if (fin) begin
         bit_len = {byte_count, 3'b000};
         pos = byte_count[5:0];
         block_bytes[pos] = 8'h80;
         pos++;
         // No room left for the length field, so the padding spills into an extra block.
         if (pos > 56) begin
            while (pos < 64) begin
               block_bytes[pos] = 8'h00;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            block_bytes[pos] = 8'h00;
            pos++;
         end
         for (k = 0; k < 8; k++) block_bytes[56 + k] = bit_len[8 * k +: 8];
         compress_block();
         for (k = 0; k < 4; k++) begin
            w.digest_word = chain_words[k];
            w.word_index  = k[1:0];
            w.last_word   = (k == 3);
            expected_words.push_back(w);
         end
         restart_message();
         messages_done++;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after the transaction is taken.
   task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (present || fin) accepted_items++;
      absorb_item(data, present, fin);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_words.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Random bytes with the odd ignored transaction mixed in; the end mark rides on the
   // last byte or comes alone.
   task automatic send_message(input int unsigned len);
      int unsigned k;
      bit end_with_byte;
      end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom()), 1'b0, 1'b0);
         send_item(8'($urandom()), 1'b1, end_with_byte && (k == len - 1));
      end
      if (!end_with_byte) send_item(8'($urandom()), 1'b0, 1'b1);
   endtask

   // Mostly short messages; some land around the padding and block boundaries.
   function automatic int unsigned pick_length();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 2) return 55 + $urandom_range(0, 10);
      else if (roll < 4) return $urandom_range(13, 130);
      else return $urandom_range(0, 12);
   endfunction

   task automatic test_directed_cases();
      send_item(8'hA5, 1'b0, 1'b1);   // empty message
      send_item(8'hFF, 1'b0, 1'b0);   // neither byte nor end
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);   // byte together with end
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);   // end alone after a byte
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b1);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_random_messages();
      int first_item, first_message;
      first_item    = accepted_items;
      first_message = messages_done;
      while (accepted_items - first_item < 120 || messages_done - first_message < 6)
         send_message(pick_length());
      stop_sending();
      wait_drained();
   endtask

   // The result side stops for a long time while messages keep coming, so the block backs up.
   task automatic test_output_hold();
      int k;
      hold_request = HOLD_CYCLES;
      for (k = 0; k < 4; k++) send_message($urandom_range(1, 8));
      stop_sending();
      wait_drained();
   endtask

   task automatic test_back_to_back();
      int first_item, first_message;
      idle_on       = 1'b0;
      stall_on      = 1'b0;
      first_item    = accepted_items;
      first_message = messages_done;
      while (accepted_items - first_item < 30 || messages_done - first_message < 2)
         send_message(pick_length());
      stop_sending();
   endtask

   initial begin : main_sequence
      real         r;
      logic [63:0] whole;
      int          i;
      for (i = 0; i < 64; i++) begin
         r = $sin(i + 1.0);
         if (r < 0.0) r = -r;
         whole = $floor(r * 4294967296.0);
         sine_table[i] = whole[31:0];
      end
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      restart_message();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_messages();
      test_output_hold();
      test_back_to_back();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : result_sink
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      digest_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("digest word with none pending", rsp_tdata, 32'h0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.digest_word)
               report_mismatch("digest_word", rsp_tdata, want.digest_word);
            if (rsp_tuser !== want.word_index)
               report_mismatch("word_index", 32'(rsp_tuser), 32'(want.word_index));
            if (rsp_tlast !== want.last_word)
               report_mismatch("last_word", 32'(rsp_tlast), 32'(want.last_word));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
